/* rtl/rgb_to_hsv_pixel_defines.svh */
// assertion macros shared by the rgb to hsv pixel rtl
// no dependencies; taken in by include where checks are written
`ifndef RGB_TO_HSV_PIXEL_DEFINES_SVH
`define RGB_TO_HSV_PIXEL_DEFINES_SVH
`ifndef ASSERT_OFF
`define RHP_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("rhp check failed");
`define RHP_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("rhp check failed");
`else
`define RHP_ASSERT_IMPLY(lbl, clk, rst_n, a, b)
`define RHP_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

/* rtl/rhp_pkg.sv */
// shared types and constants of the rgb to hsv pixel pipeline
// no dependencies
package rhp_pkg;

	typedef struct packed {
		logic black;
		logic gray;
	} flags_t;

	localparam int PREP_STAGES = 2;
	localparam int OUT_STAGES = 1;

endpackage

/* rtl/rhp_prep.sv */
// front stages: max, min, chroma and hue numerator, then the scaled dividends
// uses rhp_pkg
module rhp_prep #(
	parameter int N = 8
) (
	input  logic           clk,
	input  logic           en1,
	input  logic           en2,
	input  logic [N-1:0]   red,
	input  logic [N-1:0]   green,
	input  logic [N-1:0]   blue,
	output logic [N+2:0]   rem_h,
	output logic [N-1:0]   dl_h,
	output logic [N+2:0]   rem_s,
	output logic [N-1:0]   dl_s,
	output logic [N+2:0]   d_h,
	output logic [N-1:0]   val,
	output rhp_pkg::flags_t flags
);

	logic [N-1:0] mx, mn, c;
	logic [N+2:0] ce, num;
	logic [N-1:0] v_s1, c_s1;
	logic [N+2:0] num_s1;
	rhp_pkg::flags_t flags_s1;

	logic [2*N+2:0] prod_h;
	logic [2*N-1:0] prod_s;
	logic [N+2:0] rem_h_s2, rem_s_s2, d_h_s2;
	logic [N-1:0] dl_h_s2, dl_s_s2, v_s2;
	rhp_pkg::flags_t flags_s2;

	always_comb begin
		mx = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		c = mx - mn;
		ce = (N+3)'(c);
		if (mx == red) begin
			if (green >= blue)
				num = (N+3)'(green - blue);
			else
				num = (ce << 2) + (ce << 1) - (N+3)'(blue - green);
		end else if (mx == green) begin
			num = (ce << 1) + (N+3)'(blue) - (N+3)'(red);
		end else begin
			num = (ce << 2) + (N+3)'(red) - (N+3)'(green);
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			v_s1 <= mx;
			c_s1 <= c;
			num_s1 <= num;
			flags_s1.black <= (mx == '0);
			flags_s1.gray <= (c == '0);
		end
	end

	// full scale times x is (x << N) - x
	assign prod_h = {num_s1, {N{1'b0}}} - (2*N+3)'(num_s1);
	assign prod_s = {c_s1, {N{1'b0}}} - (2*N)'(c_s1);

	always_ff @(posedge clk) begin
		if (en2) begin
			rem_h_s2 <= prod_h[2*N+2:N];
			dl_h_s2 <= prod_h[N-1:0];
			rem_s_s2 <= (N+3)'(prod_s[2*N-1:N]);
			dl_s_s2 <= prod_s[N-1:0];
			d_h_s2 <= (N+3)'({c_s1, 2'b00}) + (N+3)'({c_s1, 1'b0});
			v_s2 <= v_s1;
			flags_s2 <= flags_s1;
		end
	end

	assign rem_h = rem_h_s2;
	assign dl_h = dl_h_s2;
	assign rem_s = rem_s_s2;
	assign dl_s = dl_s_s2;
	assign d_h = d_h_s2;
	assign val = v_s2;
	assign flags = flags_s2;

endmodule

/* rtl/rhp_div_step.sv */
// one restoring division stage for hue and saturation side by side
// uses rhp_pkg
module rhp_div_step #(
	parameter int N = 8
) (
	input  logic            clk,
	input  logic            en,
	input  logic [N+2:0]    rem_h_i,
	input  logic [N-1:0]    dl_h_i,
	input  logic [N-1:0]    q_h_i,
	input  logic [N+2:0]    rem_s_i,
	input  logic [N-1:0]    dl_s_i,
	input  logic [N-1:0]    q_s_i,
	input  logic [N+2:0]    d_h_i,
	input  logic [N-1:0]    val_i,
	input  rhp_pkg::flags_t flags_i,
	output logic [N+2:0]    rem_h_o,
	output logic [N-1:0]    dl_h_o,
	output logic [N-1:0]    q_h_o,
	output logic [N+2:0]    rem_s_o,
	output logic [N-1:0]    dl_s_o,
	output logic [N-1:0]    q_s_o,
	output logic [N+2:0]    d_h_o,
	output logic [N-1:0]    val_o,
	output rhp_pkg::flags_t flags_o
);

	logic [N+3:0] trial_h, trial_s, dh_x, ds_x, diff_h, diff_s;
	logic ge_h, ge_s;

	logic [N+2:0] rem_h_sn, rem_s_sn, d_h_sn;
	logic [N-1:0] dl_h_sn, dl_s_sn, q_h_sn, q_s_sn, val_sn;
	rhp_pkg::flags_t flags_sn;

	always_comb begin
		trial_h = {rem_h_i, dl_h_i[N-1]};
		trial_s = {rem_s_i, dl_s_i[N-1]};
		dh_x = (N+4)'(d_h_i);
		ds_x = (N+4)'(val_i);
		ge_h = trial_h >= dh_x;
		ge_s = trial_s >= ds_x;
		diff_h = ge_h ? trial_h - dh_x : trial_h;
		diff_s = ge_s ? trial_s - ds_x : trial_s;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_h_sn <= diff_h[N+2:0];
			rem_s_sn <= diff_s[N+2:0];
			dl_h_sn <= {dl_h_i[N-2:0], 1'b0};
			dl_s_sn <= {dl_s_i[N-2:0], 1'b0};
			q_h_sn <= {q_h_i[N-2:0], ge_h};
			q_s_sn <= {q_s_i[N-2:0], ge_s};
			d_h_sn <= d_h_i;
			val_sn <= val_i;
			flags_sn <= flags_i;
		end
	end

	assign rem_h_o = rem_h_sn;
	assign rem_s_o = rem_s_sn;
	assign dl_h_o = dl_h_sn;
	assign dl_s_o = dl_s_sn;
	assign q_h_o = q_h_sn;
	assign q_s_o = q_s_sn;
	assign d_h_o = d_h_sn;
	assign val_o = val_sn;
	assign flags_o = flags_sn;

endmodule

/* rtl/rhp_round.sv */
// output stage: round to nearest even, force black and gray cases, register
// uses rhp_pkg
module rhp_round #(
	parameter int N = 8
) (
	input  logic            clk,
	input  logic            en,
	input  logic [N+2:0]    rem_h,
	input  logic [N-1:0]    q_h,
	input  logic [N+2:0]    rem_s,
	input  logic [N-1:0]    q_s,
	input  logic [N+2:0]    d_h,
	input  logic [N-1:0]    val,
	input  rhp_pkg::flags_t flags,
	output logic [N-1:0]    hue,
	output logic [N-1:0]    saturation,
	output logic [N-1:0]    value_level
);

	logic [N+3:0] twice_h, twice_s, dh_x, ds_x;
	logic up_h, up_s;
	logic [N-1:0] hue_r, sat_r;
	logic [N-1:0] hue_so, sat_so, val_so;

	always_comb begin
		twice_h = {rem_h, 1'b0};
		twice_s = {rem_s, 1'b0};
		dh_x = (N+4)'(d_h);
		ds_x = (N+4)'(val);
		up_h = (twice_h > dh_x) || ((twice_h == dh_x) && q_h[0]);
		up_s = (twice_s > ds_x) || ((twice_s == ds_x) && q_s[0]);
		hue_r = q_h + N'(up_h);
		sat_r = q_s + N'(up_s);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_so <= (flags.black || flags.gray) ? '0 : hue_r;
			sat_so <= flags.black ? '0 : sat_r;
			val_so <= val;
		end
	end

	assign hue = hue_so;
	assign saturation = sat_so;
	assign value_level = val_so;

endmodule

/* rtl/rgb_to_hsv_pixel.sv */
// rgb to hsv pixel converter, top level
// uses rhp_pkg, rhp_prep, rhp_div_step, rhp_round and the assertion macros
//
// usage:
//   input channel: pix_valid, pix_stall, red, green, blue
//   output channel: hsv_valid, hsv_stall, hue, saturation, value_level
//   an item moves when valid is high and stall is low at a rising clk edge
// pipeline: two front stages, one stage per quotient bit of the restoring
//   dividers, one rounding stage
// throughput: one pixel per clock unless stalled; hue and saturation quotients
//   each have their own divider stage per bit; nothing is shared between pixels
// stall: each stage moves when it is empty or the stage after it moves, so
//   bubbles are squeezed out; pix_stall rises only when every stage holds an
//   item and hsv_stall is high
// reset: arst_n clears all valid bits at once; data registers are not reset
`include "rgb_to_hsv_pixel_defines.svh"
module rgb_to_hsv_pixel #(
	parameter int CHANNEL_BITS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    pix_valid,
	output logic                    pix_stall,
	input  logic [CHANNEL_BITS-1:0] red,
	input  logic [CHANNEL_BITS-1:0] green,
	input  logic [CHANNEL_BITS-1:0] blue,
	output logic                    hsv_valid,
	input  logic                    hsv_stall,
	output logic [CHANNEL_BITS-1:0] hue,
	output logic [CHANNEL_BITS-1:0] saturation,
	output logic [CHANNEL_BITS-1:0] value_level
);

	localparam int N = CHANNEL_BITS;
	localparam int STAGES = rhp_pkg::PREP_STAGES + N + rhp_pkg::OUT_STAGES;

	logic [STAGES-1:0] vld_q;
	logic [STAGES-1:0] en;

	logic [N+2:0] rem_h_c [N+1];
	logic [N-1:0] dl_h_c [N+1];
	logic [N-1:0] q_h_c [N+1];
	logic [N+2:0] rem_s_c [N+1];
	logic [N-1:0] dl_s_c [N+1];
	logic [N-1:0] q_s_c [N+1];
	logic [N+2:0] d_h_c [N+1];
	logic [N-1:0] val_c [N+1];
	rhp_pkg::flags_t flags_c [N+1];

	assign en[STAGES-1] = !vld_q[STAGES-1] || !hsv_stall;

	genvar k;
	generate
		for (k = 0; k < STAGES - 1; k++) begin : g_en
			assign en[k] = !vld_q[k] || en[k+1];
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= pix_valid;
			for (int i = 1; i < STAGES; i++) begin
				if (en[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	assign pix_stall = !en[0];
	assign hsv_valid = vld_q[STAGES-1];

	rhp_prep #(.N(N)) u_prep (
		.clk   (clk),
		.en1   (en[0]),
		.en2   (en[1]),
		.red   (red),
		.green (green),
		.blue  (blue),
		.rem_h (rem_h_c[0]),
		.dl_h  (dl_h_c[0]),
		.rem_s (rem_s_c[0]),
		.dl_s  (dl_s_c[0]),
		.d_h   (d_h_c[0]),
		.val   (val_c[0]),
		.flags (flags_c[0])
	);

	assign q_h_c[0] = '0;
	assign q_s_c[0] = '0;

	generate
		for (k = 0; k < N; k++) begin : g_div
			rhp_div_step #(.N(N)) u_step (
				.clk     (clk),
				.en      (en[rhp_pkg::PREP_STAGES + k]),
				.rem_h_i (rem_h_c[k]),
				.dl_h_i  (dl_h_c[k]),
				.q_h_i   (q_h_c[k]),
				.rem_s_i (rem_s_c[k]),
				.dl_s_i  (dl_s_c[k]),
				.q_s_i   (q_s_c[k]),
				.d_h_i   (d_h_c[k]),
				.val_i   (val_c[k]),
				.flags_i (flags_c[k]),
				.rem_h_o (rem_h_c[k+1]),
				.dl_h_o  (dl_h_c[k+1]),
				.q_h_o   (q_h_c[k+1]),
				.rem_s_o (rem_s_c[k+1]),
				.dl_s_o  (dl_s_c[k+1]),
				.q_s_o   (q_s_c[k+1]),
				.d_h_o   (d_h_c[k+1]),
				.val_o   (val_c[k+1]),
				.flags_o (flags_c[k+1])
			);
		end
	endgenerate

	rhp_round #(.N(N)) u_round (
		.clk         (clk),
		.en          (en[STAGES-1]),
		.rem_h       (rem_h_c[N]),
		.q_h         (q_h_c[N]),
		.rem_s       (rem_s_c[N]),
		.q_s         (q_s_c[N]),
		.d_h         (d_h_c[N]),
		.val         (val_c[N]),
		.flags       (flags_c[N]),
		.hue         (hue),
		.saturation  (saturation),
		.value_level (value_level)
	);

	// black item carries zero hue and saturation
	`RHP_ASSERT_IMPLY(a_black_zero, clk, arst_n, hsv_valid && (value_level == '0), (hue == '0) && (saturation == '0))
	// zero saturation only comes from a gray item
	`RHP_ASSERT_IMPLY(a_gray_hue, clk, arst_n, hsv_valid && (saturation == '0), hue == '0)
	// input stalls only when the pipe is full and the output is held
	`RHP_ASSERT_IMPLY(a_stall_full, clk, arst_n, pix_stall, (vld_q == '1) && hsv_stall)
	// a held output item stays valid in the next cycle
	`RHP_ASSERT_NEXT(a_hold_out, clk, arst_n, hsv_valid && hsv_stall, hsv_valid)

endmodule

/* bench/testbench.sv */
// self-checking bench for the rgb to hsv pixel converter
// drives pixels with random idling and backpressure, predicts each hsv item
// with its own exact-rounding model; needs only rgb_to_hsv_pixel
`timescale 1ns / 1ps
module testbench;

	localparam int CB = 8;
	localparam int unsigned FULL = (1 << CB) - 1;
	localparam int LATENCY = CB + 3;
	localparam int LONG_HOLD = 120;

	typedef logic [CB-1:0] chan_t;

	typedef struct packed {
		chan_t hue;
		chan_t sat;
		chan_t val;
	} hsv_t;

	typedef enum int {
		KIND_ANY,
		KIND_GRAY,
		KIND_TIE,
		KIND_EDGE,
		KIND_DIM
	} pix_kind_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  pix_valid = 1'b0;
	logic  pix_stall;
	chan_t red = '0;
	chan_t green = '0;
	chan_t blue = '0;
	logic  hsv_valid;
	logic  hsv_stall = 1'b0;
	chan_t hue;
	chan_t saturation;
	chan_t value_level;

	hsv_t pending_hsv [$];
	hsv_t want_hsv;
	int   fail_count = 0;
	bit   tx_idle_on = 1'b1;
	bit   rx_idle_on = 1'b1;
	int   hold_asked = 0;
	int   hold_given = 0;
	int   hold_left = 0;
	int   stall_left = 0;

	rgb_to_hsv_pixel #(
		.CHANNEL_BITS(CB)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.hsv_valid  (hsv_valid),
		.hsv_stall  (hsv_stall),
		.hue        (hue),
		.saturation (saturation),
		.value_level(value_level)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int unsigned div_nearest_even(input int unsigned n, input int unsigned d);
		int unsigned q;
		int unsigned r;
		q = n / d;
		r = n % d;
		if (2 * r > d || (2 * r == d && q[0]))
			q++;
		return q;
	endfunction

	function automatic hsv_t hsv_of(input chan_t r, input chan_t g, input chan_t b);
		hsv_t        res;
		int unsigned top;
		int unsigned low;
		int unsigned chroma;
		int unsigned num;
		res = '0;
		top = r;
		if (g > top) top = g;
		if (b > top) top = b;
		low = r;
		if (g < low) low = g;
		if (b < low) low = b;
		res.val = chan_t'(top);
		if (top != 0) begin
			chroma = top - low;
			res.sat = chan_t'(div_nearest_even(FULL * chroma, top));
			if (chroma != 0) begin
				if (top == r)
					num = (g >= b) ? g - b : 6 * chroma - (b - g);
				else if (top == g)
					num = 2 * chroma + b - r;
				else
					num = 4 * chroma + r - g;
				res.hue = chan_t'(div_nearest_even(FULL * num, 6 * chroma));
			end
		end
		return res;
	endfunction

	// receiver: random stall bursts, or one long hold when asked
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hsv_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_given != hold_asked) begin
			hsv_stall <= 1'b1;
			hold_given <= hold_asked;
			hold_left <= LONG_HOLD - 1;
		end else if (stall_left > 0) begin
			hsv_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
			hsv_stall <= 1'b1;
			stall_left <= $urandom_range(0, 5);
		end else begin
			hsv_stall <= 1'b0;
		end
	end

	// outputs and stall only move at the rising edge, so sample between edges
	always @(negedge clk) begin
		if (arst_n && hsv_valid && !hsv_stall) begin
			if (pending_hsv.size() == 0) begin
				fail_count++;
				$display("%0t unexpected item: expected none, actual %0d %0d %0d",
					$time, hue, saturation, value_level);
			end else begin
				want_hsv = pending_hsv.pop_front();
				if (hue !== want_hsv.hue || saturation !== want_hsv.sat ||
						value_level !== want_hsv.val) begin
					fail_count++;
					$display("%0t hsv mismatch: expected %0d %0d %0d, actual %0d %0d %0d",
						$time, want_hsv.hue, want_hsv.sat, want_hsv.val,
						hue, saturation, value_level);
				end
			end
		end
	end

	task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b);
		bit taken;
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		pix_valid <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		do begin
			@(negedge clk);
			taken = !pix_stall;
			if (taken)
				pending_hsv.push_back(hsv_of(r, g, b));
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic wait_for_results();
		pix_valid <= 1'b0;
		while (pending_hsv.size() != 0)
			@(posedge clk);
	endtask

	function automatic chan_t edge_level();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return chan_t'(1);
			2: return chan_t'(FULL - 1);
			default: return chan_t'(FULL);
		endcase
	endfunction

	task automatic send_random_pixel();
		pix_kind_t kind;
		chan_t     a;
		chan_t     c;
		kind = pix_kind_t'($urandom_range(0, 4));
		a = chan_t'($urandom);
		c = chan_t'($urandom_range(0, a));
		case (kind)
			KIND_GRAY: send_pixel(a, a, a);
			KIND_TIE: begin
				case ($urandom_range(0, 2))
					0: send_pixel(a, a, c);
					1: send_pixel(a, c, a);
					default: send_pixel(c, a, a);
				endcase
			end
			KIND_EDGE: send_pixel(edge_level(), edge_level(), edge_level());
			KIND_DIM: send_pixel(chan_t'($urandom_range(0, 3)),
				chan_t'($urandom_range(0, 3)), chan_t'($urandom_range(0, 3)));
			default: send_pixel(chan_t'($urandom), chan_t'($urandom), chan_t'($urandom));
		endcase
	endtask

	// black, gray, primaries, ties for the maximum, red wrap, rounding ties
	task automatic test_directed();
		logic [3*CB-1:0] pixels [$];
		pixels = '{24'h000000, 24'hffffff, 24'h808080, 24'h010101,
			24'hff0000, 24'h00ff00, 24'h0000ff, 24'hffff00,
			24'h00ffff, 24'hff00ff, 24'hff0001, 24'hff0100,
			24'h010000, 24'h000100, 24'h000001, 24'hfffe00,
			24'h00fffe, 24'hfe00ff, 24'hc86496, 24'h020101,
			24'h020201, 24'h010100, 24'h0100ff, 24'hff00fe};
		foreach (pixels[i])
			send_pixel(pixels[i][23:16], pixels[i][15:8], pixels[i][7:0]);
		wait_for_results();
	endtask

	task automatic test_random_mix();
		repeat (320)
			send_random_pixel();
	endtask

	// receiver holds off long enough that the pipeline fills and stalls input
	task automatic test_backpressure();
		hold_asked++;
		repeat (50)
			send_random_pixel();
		wait_for_results();
	endtask

	task automatic test_pause_drain();
		repeat (3) begin
			repeat (15)
				send_random_pixel();
			wait_for_results();
		end
	endtask

	task automatic test_no_idle();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		repeat (250)
			send_random_pixel();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_mix();
		test_backpressure();
		test_pause_drain();
		test_no_idle();
		wait_for_results();
		repeat (LATENCY + 4) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
